### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define KIBF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define KIBF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/kibf_pkg.sv
// ----------------------------------------------------------------------------
// kibf_pkg
// Types, field layout and constants of the keyframe blend factor block.
// ----------------------------------------------------------------------------
`default_nettype none

package kibf_pkg;

  // Default sizes
  localparam int MAX_KEYS_DEF  = 256;
  localparam int TICK_BITS_DEF = 24;

  // Field widths
  localparam int KEY_IDX_W    = 8;
  localparam int TICK_FIELD_W = 24;
  localparam int KEY_COUNT_W  = 9;
  localparam int TPK_W        = 16;
  localparam int BLEND_W      = 17;
  localparam int FRAC_BITS    = 16;

  // Input beat layout (tdata), lowest bit first
  localparam int IDX_LO    = 0;
  localparam int KTICK_LO  = IDX_LO + KEY_IDX_W;
  localparam int TTICK_LO  = KTICK_LO + TICK_FIELD_W;
  localparam int LOOP_LO   = TTICK_LO + TICK_FIELD_W;
  localparam int S_TDATA_W = 64;

  // Output beat layout (tdata), lowest bit first
  localparam int LOWER_LO  = 0;
  localparam int UPPER_LO  = LOWER_LO + KEY_IDX_W;
  localparam int BLEND_LO  = UPPER_LO + KEY_IDX_W;
  localparam int M_TDATA_W = 40;
  localparam int M_PAD_W   = M_TDATA_W - BLEND_LO - BLEND_W;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RST = 9'd2;
  localparam logic [TPK_W-1:0]       TPK_RST       = 16'd1;
  localparam logic [BLEND_W-1:0]     ONE_Q16       = 17'h10000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_KEY_COUNT     = 1'b0,
    REG_TICKS_PER_KEY = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } item_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LAST,
    S_MOD,
    S_CLASS,
    S_GUESS,
    S_SEED,
    S_DOWN,
    S_UP,
    S_BLEND,
    S_FRAC,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### rtl/core/keyframe_interval_blend_factor_top.sv
// ----------------------------------------------------------------------------
// keyframe_interval_blend_factor_top
// Keyframe tick table with interval search and Q16 blend factor.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          content
//  cfg      in   cfg_we             key_count (idx 0), ticks_per_key (idx 1)
//  s        in   s_tvalid/s_tready  write beat or query beat, kind on tuser
//  m        out  m_tvalid/m_tready  lower key, upper key, blend factor
//
//  A write beat goes into the table as it is taken. A query runs the
//  bit-serial divider (one quotient bit per cycle) for the loop wrap when
//  looping is set, for the start guess and, unless the factor is 0 or
//  1.0, for the blend fraction; a table read backs each search step.
//  Beyond the last key a query skips the start guess and the search.
//  Reset is synchronous and leaves the table contents as they were.
//  s_tready is high only while no query is in work; the table is written
//  only then, so reads and writes never overlap. A finished result waits in
//  the output register without holding off the next beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module keyframe_interval_blend_factor_top #(
  parameter int MAX_KEYS  = kibf_pkg::MAX_KEYS_DEF,
  parameter int TICK_BITS = kibf_pkg::TICK_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration
  input  logic                            cfg_we,
  input  logic [kibf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [kibf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // key_index[7:0], key_tick[31:8], time_tick[55:32], looping[56], zeros
  input  logic [kibf_pkg::S_TDATA_W-1:0]  s_tdata,
  // kind[0]
  input  logic                            s_tuser,
  // Output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // lower_key[7:0], upper_key[15:8], blend_q16[32:16], zeros
  output logic [kibf_pkg::M_TDATA_W-1:0]  m_tdata
);

  import kibf_pkg::*;

  localparam int AW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int NCW  = $clog2(MAX_KEYS + 1);
  localparam int KW   = (NCW > KEY_COUNT_W) ? NCW : KEY_COUNT_W;
  localparam int IXW  = (NCW > KEY_IDX_W) ? NCW : KEY_IDX_W;
  localparam int OW   = (AW > KEY_IDX_W) ? AW : KEY_IDX_W;
  localparam int TXW  = (TICK_BITS > TICK_FIELD_W) ? TICK_BITS : TICK_FIELD_W;
  localparam int QW   = (TICK_BITS > TPK_W) ? TICK_BITS : TPK_W;
  localparam int DW   = QW + 1;
  localparam int CW   = $clog2(QW + 1);
  localparam int GW   = (QW > KW) ? QW : KW;

  // Configuration registers
  logic [KEY_COUNT_W-1:0] key_count;
  logic [TPK_W-1:0]       tpk;

  // Control
  state_t state, state_next;

  // Query datapath registers
  logic [TICK_BITS-1:0] t_q;
  logic                 looping_q;
  logic [TICK_BITS-1:0] tl;
  logic [TICK_BITS-1:0] lo_tick;
  logic [TICK_BITS-1:0] hi_tick;
  logic [AW-1:0]        lower;
  logic [AW-1:0]        upper;
  logic [BLEND_W-1:0]   blend;

  // Serial divider registers
  logic [DW-1:0]        div_r;
  logic [DW-1:0]        div_d;
  logic [TICK_BITS-1:0] div_s;
  logic [QW-1:0]        div_q;
  logic [CW-1:0]        div_cnt;

  // Input beat fields
  logic [KEY_IDX_W-1:0]    in_index;
  logic [TXW-1:0]          key_tick_ext;
  logic [TXW-1:0]          time_tick_ext;
  logic [TICK_BITS-1:0]    in_key_tick;
  logic [TICK_BITS-1:0]    in_time;
  logic                    in_looping;
  item_kind_t              in_kind;
  logic                    accept;
  logic [IXW-1:0]          idx_ext;

  // Table port
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [AW-1:0]        ram_raddr;
  logic [TICK_BITS-1:0] ram_rdata;

  // Derived configuration
  logic [KW-1:0]    kc_ext;
  logic [KW-1:0]    n_eff;
  logic [KW-1:0]    n_m2;
  logic [AW-1:0]    last;
  logic [TPK_W-1:0] tpk_eff;

  // Combinational helpers
  logic [DW:0]          div_r2;
  logic                 div_ge;
  logic [DW-1:0]        div_r_step;
  logic [QW-1:0]        div_q_step;
  logic                 div_last;
  logic [GW-1:0]        guess_ext;
  logic [GW-1:0]        nm2_ext;
  logic [AW-1:0]        guess_sat;
  logic                 gap;
  logic                 dn_go;
  logic                 up_go;
  logic [AW-1:0]        lower_dec;
  logic [AW-1:0]        lower_inc;
  logic [TICK_BITS-1:0] frac_num;
  logic [DW-1:0]        frac_den;
  logic                 frac_sat;
  logic                 blend_zero;
  logic                 out_free;
  logic [OW-1:0]        lower_ext;
  logic [OW-1:0]        upper_ext;
  logic                 div_busy;
  logic                 walk_busy;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= KEY_COUNT_RST;
      tpk       <= TPK_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_KEY_COUNT:     key_count <= cfg_wdata[KEY_COUNT_W-1:0];
        REG_TICKS_PER_KEY: tpk       <= cfg_wdata[TPK_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective key count, last index, ticks per key
  assign kc_ext  = KW'(key_count);
  assign n_eff   = (kc_ext < KW'(2)) ? KW'(2) :
                   (kc_ext > KW'(MAX_KEYS)) ? KW'(MAX_KEYS) : kc_ext;
  assign n_m2    = n_eff - KW'(2);
  assign last    = AW'(n_eff - KW'(1));
  assign tpk_eff = (tpk == '0) ? TPK_W'(1) : tpk;

  // Input beat unpacking; no beat is taken while in reset
  assign s_tready      = (state == S_IDLE) && !rst;
  assign accept        = s_tvalid && s_tready;
  assign in_kind       = item_kind_t'(s_tuser);
  assign in_index      = s_tdata[IDX_LO +: KEY_IDX_W];
  assign key_tick_ext  = TXW'(s_tdata[KTICK_LO +: TICK_FIELD_W]);
  assign time_tick_ext = TXW'(s_tdata[TTICK_LO +: TICK_FIELD_W]);
  assign in_key_tick   = key_tick_ext[TICK_BITS-1:0];
  assign in_time       = time_tick_ext[TICK_BITS-1:0];
  assign in_looping    = s_tdata[LOOP_LO];

  // Table write; indices past the table are dropped
  assign idx_ext   = IXW'(in_index);
  assign ram_we    = accept && (in_kind == KIND_WRITE) && (idx_ext < IXW'(MAX_KEYS));
  assign ram_waddr = idx_ext[AW-1:0];

  kibf_ram #(
    .WIDTH (TICK_BITS),
    .DEPTH (MAX_KEYS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_key_tick),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Restoring divider step, one quotient bit
  assign div_r2     = {div_r, div_s[TICK_BITS-1]};
  assign div_ge     = (div_r2 >= {1'b0, div_d});
  assign div_r_step = div_ge ? DW'(div_r2 - {1'b0, div_d}) : div_r2[DW-1:0];
  assign div_q_step = {div_q[QW-2:0], div_ge};
  assign div_last   = (div_cnt == CW'(1));

  // Start guess, saturated to the effective key count - 2
  assign guess_ext = GW'(div_q_step);
  assign nm2_ext   = GW'(n_m2);
  assign guess_sat = (guess_ext > nm2_ext) ? AW'(n_m2) : AW'(guess_ext);

  // Search conditions, table word for the tested entry on ram_rdata
  assign gap       = (t_q > tl);
  assign lower_dec = lower - AW'(1);
  assign lower_inc = lower + AW'(1);
  assign dn_go     = (lower != '0) && (ram_rdata > t_q);
  assign up_go     = (KW'(lower) < n_m2) && (ram_rdata <= t_q);

  // Blend operands: loop gap or key interval
  assign frac_num   = (state == S_CLASS) ? (t_q - tl) : (t_q - lo_tick);
  assign frac_den   = (state == S_CLASS) ? DW'(tpk_eff) : DW'(hi_tick - lo_tick);
  assign frac_sat   = (DW'(frac_num) >= frac_den);
  assign blend_zero = (hi_tick <= lo_tick) || (t_q < lo_tick);

  assign out_free = !m_tvalid || m_tready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and table read address
  always_comb begin
    state_next = state;
    ram_raddr  = lower;
    unique case (state)
      S_IDLE: begin
        ram_raddr = last;
        if (accept && (in_kind == KIND_QUERY)) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        state_next = looping_q ? S_MOD : S_CLASS;
      end
      S_MOD: begin
        if (div_last) begin
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        if (!gap) begin
          state_next = S_GUESS;
        end else if (looping_q && !frac_sat) begin
          state_next = S_FRAC;
        end else begin
          state_next = S_DONE;
        end
      end
      S_GUESS: begin
        if (div_last) begin
          state_next = S_SEED;
        end
      end
      S_SEED: begin
        ram_raddr  = lower;
        state_next = S_DOWN;
      end
      S_DOWN: begin
        if (dn_go) begin
          ram_raddr = lower_dec;
        end else begin
          ram_raddr  = lower_inc;
          state_next = S_UP;
        end
      end
      S_UP: begin
        if (up_go) begin
          ram_raddr = lower_inc + AW'(1);
        end else begin
          state_next = S_BLEND;
        end
      end
      S_BLEND: begin
        state_next = (blend_zero || frac_sat) ? S_DONE : S_FRAC;
      end
      S_FRAC: begin
        if (div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Query datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        t_q       <= in_time;
        looping_q <= in_looping;
      end
      S_LAST: begin
        // last tick arrives; loop mode wraps time by last tick + gap
        tl      <= ram_rdata;
        div_r   <= '0;
        div_d   <= DW'(ram_rdata) + DW'(tpk_eff);
        div_s   <= t_q;
        div_q   <= '0;
        div_cnt <= CW'(TICK_BITS);
      end
      S_MOD, S_GUESS, S_FRAC: begin
        div_r   <= div_r_step;
        div_s   <= {div_s[TICK_BITS-2:0], 1'b0};
        div_q   <= div_q_step;
        div_cnt <= div_cnt - CW'(1);
        if (div_last) begin
          if (state == S_MOD) begin
            t_q <= div_r_step[TICK_BITS-1:0];
          end else if (state == S_GUESS) begin
            lower <= guess_sat;
          end else begin
            blend <= BLEND_W'(div_q_step[FRAC_BITS-1:0]);
          end
        end
      end
      S_CLASS: begin
        if (gap) begin
          // past the last key: hold it, or blend toward key 0 when looping
          lower <= last;
          upper <= looping_q ? '0 : last;
          blend <= (looping_q && frac_sat) ? ONE_Q16 : '0;
          div_r   <= DW'(frac_num);
          div_d   <= frac_den;
          div_s   <= '0;
          div_q   <= '0;
          div_cnt <= CW'(FRAC_BITS);
        end else begin
          // start guess = time / ticks_per_key
          div_r   <= '0;
          div_d   <= DW'(tpk_eff);
          div_s   <= t_q;
          div_q   <= '0;
          div_cnt <= CW'(TICK_BITS);
        end
      end
      S_DOWN: begin
        if (dn_go) begin
          lower <= lower_dec;
        end else begin
          lo_tick <= ram_rdata;
        end
      end
      S_UP: begin
        if (up_go) begin
          lower   <= lower_inc;
          lo_tick <= ram_rdata;
        end else begin
          hi_tick <= ram_rdata;
          upper   <= lower_inc;
        end
      end
      S_BLEND: begin
        blend   <= (!blend_zero && frac_sat) ? ONE_Q16 : '0;
        div_r   <= DW'(frac_num);
        div_d   <= frac_den;
        div_s   <= '0;
        div_q   <= '0;
        div_cnt <= CW'(FRAC_BITS);
      end
      default: ;
    endcase
  end

  // Output register
  assign lower_ext = OW'(lower);
  assign upper_ext = OW'(upper);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if ((state == S_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      m_tdata <= {M_PAD_W'(0), blend, upper_ext[KEY_IDX_W-1:0], lower_ext[KEY_IDX_W-1:0]};
    end
  end

  // Checks
  assign div_busy  = (state == S_MOD) || (state == S_GUESS) || (state == S_FRAC);
  assign walk_busy = (state == S_DOWN) || (state == S_UP) || (state == S_BLEND);

  `KIBF_ASSERT(a_wr_idle, ram_we |-> (state == S_IDLE), "table written during a query")
  `KIBF_ASSERT(a_lower_range, walk_busy |-> (KW'(lower) <= n_m2), "search out of range")
  `KIBF_ASSERT(a_div_cnt, div_busy |-> (div_cnt != '0), "divider ran out of steps")
  `KIBF_ASSERT(a_blend_max, m_tvalid |-> (m_tdata[BLEND_LO +: BLEND_W] <= ONE_Q16), "blend > 1.0")
  `KIBF_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> state == S_IDLE && !m_tvalid, "reset not idle")

endmodule

`default_nettype wire

### rtl/core/kibf_ram.sv
// ----------------------------------------------------------------------------
// kibf_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kibf_ram #(
  parameter int  WIDTH  = 8,
  parameter int  DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### tb/tb_keyframe_interval_blend_factor_top.sv
// ----------------------------------------------------------------------------
// tb_keyframe_interval_blend_factor_top
// Self-checking bench for the keyframe interval blend factor block.
// Loads keyframe tick tables through write beats and fires time queries, with
// and without looping, under several key count and ticks-per-key settings.
// Each query beat is predicted as it is accepted. Every result beat is checked
// field by field against the oldest prediction. Both stream sides idle at
// random, and the result side holds off for long stretches so that the input
// backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_keyframe_interval_blend_factor_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kibf_pkg::*;

  localparam int          TABLE_DEPTH   = MAX_KEYS_DEF;
  localparam int unsigned TICK_MAX      = (1 << TICK_FIELD_W) - 1;
  localparam int          SETTLE_CYCLES = 8;
  // Slowest query: three serial divisions plus a walk down and back up the table
  localparam int          DRAIN_CYCLES  = 2 * TICK_BITS_DEF + 24 + 2 * MAX_KEYS_DEF + 50;
  localparam int          HOLD_CYCLES   = 600;
  // Longest quiet spell: hold-off + slowest query + sender gap
  localparam int          QUIET_LIMIT   = 6000;

  typedef struct packed {
    item_kind_t              kind;
    logic [KEY_IDX_W-1:0]    idx;
    logic [TICK_FIELD_W-1:0] key_tick;
    logic [TICK_FIELD_W-1:0] time_tick;
    logic                    looping;
  } key_beat_t;

  typedef struct packed {
    logic [KEY_IDX_W-1:0] lower;
    logic [KEY_IDX_W-1:0] upper;
    logic [BLEND_W-1:0]   blend;
  } blend_result_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_EVERY_THIRD,
    RX_SPARSE
  } rx_mode_t;

  // DUT connections
  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  cfg_reg_t              cfg_addr  = REG_KEY_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;

  // Own copy of the block's table and registers, used for prediction
  logic [TICK_FIELD_W-1:0] key_ticks [TABLE_DEPTH];
  logic [KEY_COUNT_W-1:0]  key_count_reg = KEY_COUNT_RST;
  logic [TPK_W-1:0]        tpk_reg       = TPK_RST;
  blend_result_t           expected_blends [$];

  // Stimulus side: planned table contents and beats waiting to be sent
  logic [TICK_FIELD_W-1:0] plan_ticks [TABLE_DEPTH];
  key_beat_t               pending_beats [$];

  logic s_taken = 1'b0;
  int   beats_queued    = 0;
  int   beats_taken     = 0;
  int   results_checked = 0;
  int   fail_count      = 0;
  int   reg_writes      = 0;
  int   gap_count       = 0;
  int   held_count      = 0;
  int   full_count      = 0;
  int   zero_count      = 0;

  keyframe_interval_blend_factor_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Blend factor prediction
  // --------------------------------------------------------------------------
  function automatic logic [BLEND_W-1:0] q16_ratio(input longint unsigned num,
                                                   input longint unsigned den);
    longint unsigned f;
    if (den == 0) return '0;
    f = (num << FRAC_BITS) / den;
    return (f > ONE_Q16) ? ONE_Q16 : f[BLEND_W-1:0];
  endfunction

  function automatic blend_result_t predict_blend(input logic [TICK_FIELD_W-1:0] t_in,
                                                  input logic looping);
    blend_result_t   r;
    int unsigned     n, last, lower;
    longint unsigned t, tl, tpk, lo_t, hi_t, guess;
    n = (key_count_reg < 2) ? 2 :
        (key_count_reg > TABLE_DEPTH) ? TABLE_DEPTH : key_count_reg;
    last = n - 1;
    tl   = key_ticks[last];
    tpk  = (tpk_reg == 0) ? 1 : tpk_reg;
    t    = t_in;
    // loop mode wraps over the whole cycle, gap after the last key included
    if (looping) t = t % (tl + tpk);
    if (t > tl) begin
      r.lower = last[KEY_IDX_W-1:0];
      r.upper = looping ? '0 : last[KEY_IDX_W-1:0];
      r.blend = looping ? q16_ratio(t - tl, tpk) : '0;
    end else begin
      // start at the average-spacing guess, then walk to the enclosing interval
      guess = t / tpk;
      lower = (guess > n - 2) ? n - 2 : 32'(guess);
      while (lower > 0 && key_ticks[lower] > t) lower--;
      while (lower < n - 2 && key_ticks[lower + 1] <= t) lower++;
      lo_t    = key_ticks[lower];
      hi_t    = key_ticks[lower + 1];
      r.lower = lower[KEY_IDX_W-1:0];
      r.upper = KEY_IDX_W'(lower + 1);
      r.blend = (hi_t <= lo_t || t < lo_t) ? '0 : q16_ratio(t - lo_t, hi_t - lo_t);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_write(input logic [KEY_IDX_W-1:0] idx,
                                      input logic [TICK_FIELD_W-1:0] tick);
    key_beat_t b;
    b.kind      = KIND_WRITE;
    b.idx       = idx;
    b.key_tick  = tick;
    b.time_tick = TICK_FIELD_W'($urandom);
    b.looping   = 1'($urandom);
    pending_beats.push_back(b);
    beats_queued++;
    plan_ticks[idx] = tick;
  endfunction

  function automatic void queue_query(input logic [TICK_FIELD_W-1:0] t,
                                      input logic looping);
    key_beat_t b;
    b.kind      = KIND_QUERY;
    b.idx       = KEY_IDX_W'($urandom);
    b.key_tick  = TICK_FIELD_W'($urandom);
    b.time_tick = t;
    b.looping   = looping;
    pending_beats.push_back(b);
    beats_queued++;
  endfunction

  // Block is idle once every beat is taken and every result is back
  task automatic wait_idle();
    do @(negedge clk);
    while (beats_taken != beats_queued || expected_blends.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= which;
    cfg_wdata <= value;
    if (which == REG_KEY_COUNT) key_count_reg = value[KEY_COUNT_W-1:0];
    else tpk_reg = value[TPK_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  // One setting: program registers, load one entry per effective key, then mostly queries
  task automatic run_phase(input int unsigned kc, input int unsigned tpk,
                           input int unsigned queries);
    int unsigned     n, tpk_eff, tl, hi, idx, pick, t, q;
    longint unsigned acc;
    bit              unordered;
    wait_idle();
    write_reg(REG_KEY_COUNT, CFG_DATA_W'(kc));
    write_reg(REG_TICKS_PER_KEY, CFG_DATA_W'(tpk));
    n       = (kc < 2) ? 2 : (kc > TABLE_DEPTH) ? TABLE_DEPTH : kc;
    tpk_eff = (tpk == 0) ? 1 : tpk;
    // mostly ascending tables with spacing near ticks_per_key; some scrambled
    unordered = ($urandom_range(0, 5) == 0);
    acc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, tpk_eff);
    for (int i = 0; i < int'(n); i++) begin
      if (unordered) begin
        queue_write(KEY_IDX_W'(i), TICK_FIELD_W'($urandom));
      end else begin
        if (i > 0)
          acc += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2 * tpk_eff);
        if (acc > TICK_MAX) acc = TICK_MAX;
        queue_write(KEY_IDX_W'(i), TICK_FIELD_W'(acc));
      end
    end
    q = 0;
    while (q < queries) begin
      if ($urandom_range(0, 19) == 0) begin
        // stray write, anywhere in the table
        idx = $urandom_range(0, TABLE_DEPTH - 1);
        queue_write(KEY_IDX_W'(idx), TICK_FIELD_W'($urandom));
      end else begin
        tl = plan_ticks[n - 1];
        hi = tl + tpk_eff;
        hi = hi + hi / 4;
        if (hi > TICK_MAX) hi = TICK_MAX;
        pick = $urandom_range(0, 9);
        case (pick)
          0:       t = $urandom_range(0, TICK_MAX);
          1:       t = ($urandom_range(0, 1) != 0) ? TICK_MAX : 0;
          2:       t = plan_ticks[$urandom_range(0, n - 1)];
          default: t = $urandom_range(0, hi);
        endcase
        queue_query(TICK_FIELD_W'(t), 1'($urandom_range(0, 1)));
        q++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of beats with random gaps
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin : sender
    key_beat_t            b;
    logic [S_TDATA_W-1:0] d;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        b = pending_beats.pop_front();
        d = '0;
        d[IDX_LO +: KEY_IDX_W]      = b.idx;
        d[KTICK_LO +: TICK_FIELD_W] = b.key_tick;
        d[TTICK_LO +: TICK_FIELD_W] = b.time_tick;
        d[LOOP_LO]                  = b.looping;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= b.kind;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: changing stall pattern, plus two long hold-offs
  // --------------------------------------------------------------------------
  rx_mode_t rx_mode    = RX_OPEN;
  int       mode_left  = 0;
  int       hold_left  = 0;
  int       holds_done = 0;

  always @(negedge clk) begin : receiver
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (holds_done < 2 && results_checked >= (holds_done + 1) * 200) begin
      // long hold-off while the sender keeps going; input has to back up
      hold_left = HOLD_CYCLES - 1;
      holds_done++;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_OPEN:        m_tready <= 1'b1;
        RX_COIN:        m_tready <= 1'($urandom_range(0, 1));
        RX_EVERY_THIRD: m_tready <= (mode_left % 3 == 0);
        default:        m_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on accepted input beats, check result beats
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    blend_result_t want, got;
    s_taken <= s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        beats_taken++;
        if (s_tuser == KIND_WRITE) begin
          key_ticks[s_tdata[IDX_LO +: KEY_IDX_W]] = s_tdata[KTICK_LO +: TICK_FIELD_W];
        end else begin
          want = predict_blend(s_tdata[TTICK_LO +: TICK_FIELD_W], s_tdata[LOOP_LO]);
          expected_blends.push_back(want);
        end
      end
      if (m_tvalid && m_tready) begin
        got.lower = m_tdata[LOWER_LO +: KEY_IDX_W];
        got.upper = m_tdata[UPPER_LO +: KEY_IDX_W];
        got.blend = m_tdata[BLEND_LO +: BLEND_W];
        if (expected_blends.size() == 0) begin
          $error("result beat with no query outstanding: %h", m_tdata);
          fail_count++;
        end else begin
          want = expected_blends.pop_front();
          results_checked++;
          if (want.upper == want.lower) held_count++;
          else if (want.upper < want.lower) gap_count++;
          if (want.blend == ONE_Q16) full_count++;
          else if (want.blend == '0) zero_count++;
          if (got.lower !== want.lower) begin
            $error("lower_key: expected %0d, got %0d", want.lower, got.lower);
            fail_count++;
          end
          if (got.upper !== want.upper) begin
            $error("upper_key: expected %0d, got %0d", want.upper, got.upper);
            fail_count++;
          end
          if (got.blend !== want.blend) begin
            $error("blend_q16: expected %0d, got %0d", want.blend, got.blend);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog: too long with no beat moving anywhere
  int quiet_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, expected_blends.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed part at reset settings: two keys, one tick per key
    queue_write(8'd0, '0);
    queue_write(8'd1, TICK_FIELD_W'(TICK_MAX));
    queue_query('0, 1'b0);
    queue_query(TICK_FIELD_W'(TICK_MAX), 1'b0);   // exactly on upper key: 1.0
    queue_query(TICK_FIELD_W'(TICK_MAX), 1'b1);
    queue_query(24'h7FFFFF, 1'b0);
    queue_write(8'd1, 24'd100);
    queue_query(24'd200, 1'b0);                    // past the end, held
    queue_query(24'd200, 1'b1);                    // wraps into the interval
    queue_query(24'd100, 1'b1);
    queue_write(8'd0, 24'd50);
    queue_query(24'd10, 1'b0);                     // before key 0
    queue_query(24'd10, 1'b1);
    queue_write(8'd0, 24'd100);                    // zero-length interval
    queue_query(24'd100, 1'b0);
    queue_write(8'd0, 24'd200);                    // descending pair
    queue_query(24'd100, 1'b0);
    queue_query(24'd150, 1'b1);
    queue_write(8'd255, TICK_FIELD_W'(TICK_MAX));  // entry beyond key count
    queue_query('0, 1'b1);

    // Register extremes, out-of-range key counts and zero ticks per key
    run_phase(2, 65535, 60);
    run_phase(256, 1, 25);
    run_phase(0, 0, 60);
    run_phase(511, 40000, 40);
    run_phase(1, 300, 60);
    run_phase(3, 65535, 60);
    for (int p = 0; p < 6; p++)
      run_phase($urandom_range(2, 48), $urandom_range(1, 5000), 40);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_blends.size() != 0) begin
      $error("%0d results never arrived", expected_blends.size());
      fail_count += expected_blends.size();
    end

    $display("Checked %0d blend results from %0d beats over %0d register writes.",
             results_checked, beats_taken, reg_writes);
    $display("Loop-gap blends %0d, held past end %0d, full-scale %0d, zero %0d.",
             gap_count, held_count, full_count, zero_count);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

### keyframe_interval_blend_factor_top.f
+incdir+rtl/core
rtl/core/kibf_pkg.sv
rtl/core/kibf_ram.sv
rtl/core/keyframe_interval_blend_factor_top.sv
tb/tb_keyframe_interval_blend_factor_top.sv
